// File: hdl/g2e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g2e_pkg
// Shared constants, types and elaboration-time helpers for the geodetic to
// local east/north/up converter.
// ----------------------------------------------------------------------------
package g2e_pkg;

    // latency of one pipelined rounding multiplier
    localparam int MUL_LAT = 4;
    localparam int CORDIC_STAGES_DEF = 32;
    localparam int HORNER_STEPS = 6;
    localparam int OUT_W = 35;

    localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;
    localparam logic signed [63:0] PI_Q40 = (PI_Q60 + 64'sd524288) >>> 20;
    localparam logic signed [63:0] HALF_PI_Q40 = (PI_Q60 + 64'sd1048576) >>> 21;

    // pi * 2^92 / 1.8e9, rounded: 1e-7 degree units to Q40 radians (shift 52)
    localparam logic [127:0] PI_Q92 = 128'h3243F6A8_885A308D_313198A2;
    localparam logic [127:0] UNITS_PER_PI = 128'd1800000000;
    localparam logic [127:0] RPU_WIDE = (PI_Q92 + (UNITS_PER_PI >> 1)) / UNITS_PER_PI;
    localparam logic signed [63:0] RAD_PER_UNIT = $signed(RPU_WIDE[63:0]);

    // first eccentricity squared, Q60
    localparam logic [127:0] E2_E19 = 128'd66943799901413165;
    localparam logic [127:0] FIVE_POW19 = 128'd19073486328125;
    localparam logic [127:0] E2_WIDE = ((E2_E19 << 42) + FIVE_POW19) / (FIVE_POW19 << 1);
    localparam logic signed [63:0] E2_Q60 = $signed(E2_WIDE[63:0]);

    localparam logic signed [63:0] A_MM = 64'sd6378137000;
    localparam logic signed [63:0] K_Q40 = 64'sd667681663043;
    localparam logic signed [63:0] OUT_LIMIT = 64'sd13000000000;
    localparam logic signed [63:0] HORNER_INIT = 64'sd231 <<< 50;

    typedef struct packed {
        logic signed [63:0] sin_lat;
        logic signed [63:0] cos_lat;
        logic signed [63:0] sin_lon;
        logic signed [63:0] cos_lon;
    } g2e_trig_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } g2e_pos_t;

    // atan(2^-i) in Q40 from the integer series in Q60
    function automatic logic signed [63:0] atan_q40(input int i);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int e;
        sum = 64'sd0;
        term = 64'sd0;
        e = 0;
        if (i == 0)
        begin
            sum = (PI_Q60 + 64'sd2) >>> 2;
        end
        else
        begin
            for (int k = 0; k < 31; k++)
            begin
                e = i * (2 * k + 1);
                if (e <= 60)
                begin
                    term = (64'sd1 <<< (60 - e)) / 64'(2 * k + 1);
                    sum = ((k & 1) != 0) ? sum - term : sum + term;
                end
            end
        end
        return (sum + 64'sd524288) >>> 20;
    endfunction

    // constant added after each Horner multiply, Q60
    function automatic logic signed [63:0] horner_add(input int k);
        logic signed [63:0] r;
        unique case (k)
            0:       r = 64'sd63 <<< 52;
            1:       r = 64'sd35 <<< 53;
            2:       r = 64'sd5 <<< 56;
            3:       r = 64'sd3 <<< 57;
            4:       r = 64'sd1 <<< 59;
            default: r = 64'sd1 <<< 60;
        endcase
        return r;
    endfunction

    // cycles from the earth-centred unit's inputs to its registered outputs
    function automatic int ecef_lat(input int stages);
        int t2;
        t2 = MUL_LAT + stages + 2;
        return t2 + 2 * MUL_LAT + HORNER_STEPS * (MUL_LAT + 1) + 3 * MUL_LAT + 1;
    endfunction

endpackage
`default_nettype wire

// File: hdl/g2e_mulsh.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g2e_mulsh
// Pipelined signed 64x64 multiply, shift right, round half away from zero
// and saturate to 64 bits. Built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module g2e_mulsh
    import g2e_pkg::*;
#(
    parameter int SHIFT = 40
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] q
);

    localparam logic [127:0] RND = 128'd1 << (SHIFT - 1);

    logic        neg0_reg;
    logic        neg1_reg;
    logic        neg2_reg;
    logic [63:0] ua_reg;
    logic [63:0] ub_reg;
    logic [63:0] p00_reg;
    logic [63:0] p01_reg;
    logic [63:0] p10_reg;
    logic [63:0] p11_reg;
    logic [127:0] sum_reg;
    logic [127:0] shifted;
    logic [63:0]  mag;
    logic signed [63:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // magnitudes; the most negative value maps to 2^63
            neg0_reg <= a[63] ^ b[63];
            ua_reg   <= a[63] ? 64'(-a) : 64'(a);
            ub_reg   <= b[63] ? 64'(-b) : 64'(b);

            neg1_reg <= neg0_reg;
            p00_reg  <= 64'(ua_reg[31:0]) * 64'(ub_reg[31:0]);
            p01_reg  <= 64'(ua_reg[31:0]) * 64'(ub_reg[63:32]);
            p10_reg  <= 64'(ua_reg[63:32]) * 64'(ub_reg[31:0]);
            p11_reg  <= 64'(ua_reg[63:32]) * 64'(ub_reg[63:32]);

            neg2_reg <= neg1_reg;
            sum_reg  <= {p11_reg, 64'd0} + {32'd0, p10_reg, 32'd0}
                      + {32'd0, p01_reg, 32'd0} + {64'd0, p00_reg} + RND;

            q_reg    <= neg2_reg ? -$signed(mag) : $signed(mag);
        end
    end

    always_comb
    begin
        shifted = sum_reg >> SHIFT;
        mag = (|shifted[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : shifted[63:0];
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// File: hdl/g2e_ecef.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g2e_ecef
// Geodetic point to earth-centred coordinates (mm Q16) plus the sine and
// cosine of its latitude and longitude (Q40). Fully pipelined.
// ----------------------------------------------------------------------------
module g2e_ecef
    import g2e_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [30:0] lat,
    input  logic signed [31:0] lon,
    input  logic signed [26:0] hgt,
    output g2e_trig_t          trig,
    output g2e_pos_t           pos
);

    localparam int M  = MUL_LAT;
    localparam int T2 = M + CORDIC_STAGES + 2;   // sine/cosine ready
    localparam int T4 = T2 + 2 * M;              // u ready
    localparam int T5 = T4 + HORNER_STEPS * (M + 1);
    localparam int T6 = T5 + M;                  // prime vertical radius ready
    localparam int T7 = T6 + M + 1;
    localparam int T8 = T7 + M;
    localparam int TRIG_DEP = T8 - T2;
    localparam int HDEP = T6 + M;
    localparam int UDEP = (HORNER_STEPS - 1) * (M + 1);

    logic signed [63:0] ang [0:1];
    logic signed [63:0] cx_reg [0:1][0:CORDIC_STAGES];
    logic signed [63:0] cy_reg [0:1][0:CORDIC_STAGES];
    logic signed [63:0] cz_reg [0:1][0:CORDIC_STAGES];
    logic               cf_reg [0:1][0:CORDIC_STAGES];
    logic signed [63:0] sin_reg [0:1];
    logic signed [63:0] cos_reg [0:1];

    logic signed [63:0] ss;
    logic signed [63:0] u;
    logic signed [63:0] u_dly_reg [0:UDEP-1];
    logic signed [63:0] acc_w [0:HORNER_STEPS];
    logic signed [63:0] n16;
    logic signed [63:0] ne;
    logic signed [63:0] n16_dly_reg [0:M-1];
    logic signed [63:0] h_dly_reg [0:HDEP-1];
    logic signed [63:0] nh_reg;
    logic signed [63:0] zarg_reg;
    logic signed [63:0] t;
    g2e_trig_t          trig_dly_reg [0:TRIG_DEP-1];
    g2e_trig_t          trig_nh;
    g2e_trig_t          trig_t7;

    g2e_mulsh #(.SHIFT(52)) u_ang_lat
    (
        .clk (clk),
        .en  (en),
        .a   (64'(lat)),
        .b   (RAD_PER_UNIT),
        .q   (ang[0])
    );

    g2e_mulsh #(.SHIFT(52)) u_ang_lon
    (
        .clk (clk),
        .en  (en),
        .a   (64'(lon)),
        .b   (RAD_PER_UNIT),
        .q   (ang[1])
    );

    // rotation CORDIC, one stage per register, latitude and longitude lanes
    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[l][0] <= K_Q40;
                cy_reg[l][0] <= 64'sd0;
                if (ang[l] > HALF_PI_Q40)
                begin
                    cz_reg[l][0] <= ang[l] - PI_Q40;
                    cf_reg[l][0] <= 1'b1;
                end
                else if (ang[l] < -HALF_PI_Q40)
                begin
                    cz_reg[l][0] <= ang[l] + PI_Q40;
                    cf_reg[l][0] <= 1'b1;
                end
                else
                begin
                    cz_reg[l][0] <= ang[l];
                    cf_reg[l][0] <= 1'b0;
                end
            end
        end

        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_stage
            localparam logic signed [63:0] ATAN_I = atan_q40(i);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (cz_reg[l][i] >= 64'sd0)
                    begin
                        cx_reg[l][i+1] <= cx_reg[l][i] - (cy_reg[l][i] >>> i);
                        cy_reg[l][i+1] <= cy_reg[l][i] + (cx_reg[l][i] >>> i);
                        cz_reg[l][i+1] <= cz_reg[l][i] - ATAN_I;
                    end
                    else
                    begin
                        cx_reg[l][i+1] <= cx_reg[l][i] + (cy_reg[l][i] >>> i);
                        cy_reg[l][i+1] <= cy_reg[l][i] - (cx_reg[l][i] >>> i);
                        cz_reg[l][i+1] <= cz_reg[l][i] + ATAN_I;
                    end
                    cf_reg[l][i+1] <= cf_reg[l][i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sin_reg[l] <= cf_reg[l][CORDIC_STAGES] ? -cy_reg[l][CORDIC_STAGES]
                                                       : cy_reg[l][CORDIC_STAGES];
                cos_reg[l] <= cf_reg[l][CORDIC_STAGES] ? -cx_reg[l][CORDIC_STAGES]
                                                       : cx_reg[l][CORDIC_STAGES];
            end
        end
    end

    // u = e2 * sin^2(lat)
    g2e_mulsh #(.SHIFT(20)) u_ss
    (
        .clk (clk),
        .en  (en),
        .a   (sin_reg[0]),
        .b   (sin_reg[0]),
        .q   (ss)
    );

    g2e_mulsh #(.SHIFT(60)) u_u
    (
        .clk (clk),
        .en  (en),
        .a   (E2_Q60),
        .b   (ss),
        .q   (u)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_dly_reg[0] <= u;
            for (int j = 1; j < UDEP; j++)
            begin
                u_dly_reg[j] <= u_dly_reg[j-1];
            end
        end
    end

    // series for 1/sqrt(1-u), Horner form, one multiply and one add per step
    assign acc_w[0] = HORNER_INIT;

    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        localparam logic signed [63:0] ADD_K = horner_add(k);
        logic signed [63:0] u_k;
        logic signed [63:0] prod;
        logic signed [63:0] acc_reg;

        if (k == 0)
        begin : g_first
            assign u_k = u;
        end
        else
        begin : g_next
            assign u_k = u_dly_reg[k * (M + 1) - 1];
        end

        g2e_mulsh #(.SHIFT(60)) u_step
        (
            .clk (clk),
            .en  (en),
            .a   (u_k),
            .b   (acc_w[k]),
            .q   (prod)
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg <= ADD_K + prod;
            end
        end

        assign acc_w[k+1] = acc_reg;
    end

    g2e_mulsh #(.SHIFT(44)) u_n16
    (
        .clk (clk),
        .en  (en),
        .a   (A_MM),
        .b   (acc_w[HORNER_STEPS]),
        .q   (n16)
    );

    g2e_mulsh #(.SHIFT(60)) u_ne
    (
        .clk (clk),
        .en  (en),
        .a   (n16),
        .b   (E2_Q60),
        .q   (ne)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_dly_reg[0] <= 64'(hgt) <<< 16;
            for (int j = 1; j < HDEP; j++)
            begin
                h_dly_reg[j] <= h_dly_reg[j-1];
            end
            n16_dly_reg[0] <= n16;
            for (int j = 1; j < M; j++)
            begin
                n16_dly_reg[j] <= n16_dly_reg[j-1];
            end
            nh_reg   <= n16 + h_dly_reg[T6-1];
            zarg_reg <= n16_dly_reg[M-1] - ne + h_dly_reg[HDEP-1];

            trig_dly_reg[0] <= '{sin_lat: sin_reg[0], cos_lat: cos_reg[0],
                                 sin_lon: sin_reg[1], cos_lon: cos_reg[1]};
            for (int j = 1; j < TRIG_DEP; j++)
            begin
                trig_dly_reg[j] <= trig_dly_reg[j-1];
            end
        end
    end

    assign trig_nh = trig_dly_reg[T6 - T2];
    assign trig_t7 = trig_dly_reg[T7 - T2 - 1];

    g2e_mulsh #(.SHIFT(40)) u_t
    (
        .clk (clk),
        .en  (en),
        .a   (nh_reg),
        .b   (trig_nh.cos_lat),
        .q   (t)
    );

    g2e_mulsh #(.SHIFT(40)) u_x
    (
        .clk (clk),
        .en  (en),
        .a   (t),
        .b   (trig_t7.cos_lon),
        .q   (pos.x)
    );

    g2e_mulsh #(.SHIFT(40)) u_y
    (
        .clk (clk),
        .en  (en),
        .a   (t),
        .b   (trig_t7.sin_lon),
        .q   (pos.y)
    );

    g2e_mulsh #(.SHIFT(40)) u_z
    (
        .clk (clk),
        .en  (en),
        .a   (zarg_reg),
        .b   (trig_t7.sin_lat),
        .q   (pos.z)
    );

    assign trig = trig_dly_reg[TRIG_DEP-1];

endmodule
`default_nettype wire

// File: hdl/geodetic_to_local_enu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// geodetic_to_local_enu
// WGS84 latitude/longitude/height to east/north/up offsets (mm) from a
// configured reference point.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     in_valid / in_stall  point_latitude, point_longitude, point_height
//  output    out_valid / out_stall east_offset, north_offset, up_offset
//  config    cfg_write            cfg_index, cfg_data
//
//  One transaction per cycle while the output is not stalled; the pipeline depth
//  is set by the CORDIC depth plus fourteen rounding multipliers in series.
//  The reference point runs through its own lane next to every transaction.
//  A stall on the output while out_valid is high freezes the whole pipeline; in_stall follows it.
//  Reset clears the valid bits and the reference registers.
// ----------------------------------------------------------------------------
module geodetic_to_local_enu
    import g2e_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [30:0]      point_latitude,
    input  logic signed [31:0]      point_longitude,
    input  logic signed [26:0]      point_height,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] east_offset,
    output logic signed [OUT_W-1:0] north_offset,
    output logic signed [OUT_W-1:0] up_offset,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data
);

    localparam logic [1:0] REG_REF_LAT = 2'd0;
    localparam logic [1:0] REG_REF_LON = 2'd1;
    localparam logic [1:0] REG_REF_HGT = 2'd2;

    localparam int M   = MUL_LAT;
    localparam int E   = ecef_lat(CORDIC_STAGES);
    localparam int LAT = E + 4 + 2 * M;

    logic signed [30:0] ref_lat_reg;
    logic signed [31:0] ref_lon_reg;
    logic signed [26:0] ref_hgt_reg;

    logic               adv;
    logic               vld_reg [0:LAT-1];

    g2e_trig_t          ptrig;
    g2e_trig_t          rtrig;
    g2e_pos_t           ppos;
    g2e_pos_t           rpos;
    g2e_trig_t          rt_dly_reg [0:M+1];

    logic signed [63:0] dx_reg;
    logic signed [63:0] dy_reg;
    logic signed [63:0] dz_reg;
    logic signed [63:0] a1;
    logic signed [63:0] a2;
    logic signed [63:0] a3;
    logic signed [63:0] a4;
    logic signed [63:0] a5;
    logic signed [63:0] a6;
    logic signed [63:0] b1;
    logic signed [63:0] b2;
    logic signed [63:0] east16_reg;
    logic signed [63:0] m_reg;
    logic signed [63:0] a5_reg;
    logic signed [63:0] a6_reg;
    logic signed [63:0] east_dly_reg [0:M-1];
    logic signed [63:0] a5_dly_reg [0:M-1];
    logic signed [63:0] a6_dly_reg [0:M-1];
    logic signed [63:0] east_q_reg;
    logic signed [63:0] north_q_reg;
    logic signed [63:0] up_q_reg;
    logic signed [OUT_W-1:0] east_reg;
    logic signed [OUT_W-1:0] north_reg;
    logic signed [OUT_W-1:0] up_reg;

    // Q16 mm to mm, ties away from zero, clamped to the output range
    function automatic logic signed [OUT_W-1:0] finish_mm(input logic signed [63:0] v16);
        logic signed [63:0] v;
        if (v16 >= 64'sd0)
        begin
            v = (v16 + 64'sd32768) >>> 16;
        end
        else
        begin
            v = -((-v16 + 64'sd32768) >>> 16);
        end
        if (v > OUT_LIMIT)
        begin
            v = OUT_LIMIT;
        end
        else if (v < -OUT_LIMIT)
        begin
            v = -OUT_LIMIT;
        end
        return $signed(v[OUT_W-1:0]);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_lat_reg <= '0;
            ref_lon_reg <= '0;
            ref_hgt_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_REF_LAT: ref_lat_reg <= $signed(cfg_data[30:0]);
                REG_REF_LON: ref_lon_reg <= $signed(cfg_data);
                REG_REF_HGT: ref_hgt_reg <= $signed(cfg_data[26:0]);
                default:     ;
            endcase
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign in_stall  = out_valid & out_stall;
    assign adv       = ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < LAT; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int j = 1; j < LAT; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    g2e_ecef #(.CORDIC_STAGES(CORDIC_STAGES)) u_point
    (
        .clk  (clk),
        .en   (adv),
        .lat  (point_latitude),
        .lon  (point_longitude),
        .hgt  (point_height),
        .trig (ptrig),
        .pos  (ppos)
    );

    g2e_ecef #(.CORDIC_STAGES(CORDIC_STAGES)) u_ref
    (
        .clk  (clk),
        .en   (adv),
        .lat  (ref_lat_reg),
        .lon  (ref_lon_reg),
        .hgt  (ref_hgt_reg),
        .trig (rtrig),
        .pos  (rpos)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg <= ppos.x - rpos.x;
            dy_reg <= ppos.y - rpos.y;
            dz_reg <= ppos.z - rpos.z;
            rt_dly_reg[0] <= rtrig;
            for (int j = 1; j < M + 2; j++)
            begin
                rt_dly_reg[j] <= rt_dly_reg[j-1];
            end
        end
    end

    // rotation by reference longitude, then latitude
    g2e_mulsh #(.SHIFT(40)) u_a1
    (
        .clk (clk), .en (adv), .a (dy_reg), .b (rt_dly_reg[0].cos_lon), .q (a1)
    );
    g2e_mulsh #(.SHIFT(40)) u_a2
    (
        .clk (clk), .en (adv), .a (dx_reg), .b (rt_dly_reg[0].sin_lon), .q (a2)
    );
    g2e_mulsh #(.SHIFT(40)) u_a3
    (
        .clk (clk), .en (adv), .a (dx_reg), .b (rt_dly_reg[0].cos_lon), .q (a3)
    );
    g2e_mulsh #(.SHIFT(40)) u_a4
    (
        .clk (clk), .en (adv), .a (dy_reg), .b (rt_dly_reg[0].sin_lon), .q (a4)
    );
    g2e_mulsh #(.SHIFT(40)) u_a5
    (
        .clk (clk), .en (adv), .a (dz_reg), .b (rt_dly_reg[0].cos_lat), .q (a5)
    );
    g2e_mulsh #(.SHIFT(40)) u_a6
    (
        .clk (clk), .en (adv), .a (dz_reg), .b (rt_dly_reg[0].sin_lat), .q (a6)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            east16_reg <= a1 - a2;
            m_reg      <= a3 + a4;
            a5_reg     <= a5;
            a6_reg     <= a6;
            east_dly_reg[0] <= east16_reg;
            a5_dly_reg[0]   <= a5_reg;
            a6_dly_reg[0]   <= a6_reg;
            for (int j = 1; j < M; j++)
            begin
                east_dly_reg[j] <= east_dly_reg[j-1];
                a5_dly_reg[j]   <= a5_dly_reg[j-1];
                a6_dly_reg[j]   <= a6_dly_reg[j-1];
            end
        end
    end

    g2e_mulsh #(.SHIFT(40)) u_b1
    (
        .clk (clk), .en (adv), .a (m_reg), .b (rt_dly_reg[M+1].sin_lat), .q (b1)
    );
    g2e_mulsh #(.SHIFT(40)) u_b2
    (
        .clk (clk), .en (adv), .a (m_reg), .b (rt_dly_reg[M+1].cos_lat), .q (b2)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            east_q_reg  <= east_dly_reg[M-1];
            north_q_reg <= a5_dly_reg[M-1] - b1;
            up_q_reg    <= b2 + a6_dly_reg[M-1];
            east_reg    <= finish_mm(east_q_reg);
            north_reg   <= finish_mm(north_q_reg);
            up_reg      <= finish_mm(up_q_reg);
        end
    end

    assign east_offset  = east_reg;
    assign north_offset = north_reg;
    assign up_offset    = up_reg;

endmodule
`default_nettype wire
